### sv/xs128_pkg.sv
// Shared types, constants and helper functions for the xorshift128 random source.
package xs128_pkg;

   localparam int WORD_W = 32;

   // Operation selector codes on the request side.
   localparam logic [1:0] FUNC_SEED  = 2'd0;
   localparam logic [1:0] FUNC_DRAW  = 2'd1;
   localparam logic [1:0] FUNC_RANGE = 2'd2;

   // Command queue between front and back.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Result queue at the back end.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Reseed runs as four chained multiply steps.
   localparam int         SEED_STEP_W = 2;
   localparam logic [1:0] SEED_LAST   = 2'd3;

   localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;

   typedef enum logic [1:0] {
      OP_SEED,
      OP_DRAW,
      OP_RANGE,
      OP_FIXED
   } op_type;

   // One classified request as it travels from front to back.
   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] seed;
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] diff;
      logic              err;
   } cmd_type;

   // Execute stage output, input to the multiply stage.
   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] diff;
      logic              err;
   } stage_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] value;
      logic              err;
   } rsp_type;

   function automatic logic [WORD_W-1:0] seed_mix(logic [WORD_W-1:0] s);
      return WORD_W'(SEED_MULT * (s ^ (s >> 30)));
   endfunction

   function automatic logic [WORD_W-1:0] seed_chain(logic [WORD_W-1:0] s,
                                                    logic [WORD_W-1:0] k);
      return WORD_W'(seed_mix(s) + k);
   endfunction

   // Generator state after reset equals a reseed with zero.
   localparam logic [WORD_W-1:0] RESET_A = seed_chain(32'd0, 32'd1);
   localparam logic [WORD_W-1:0] RESET_B = seed_chain(RESET_A, 32'd2);
   localparam logic [WORD_W-1:0] RESET_C = seed_chain(RESET_B, 32'd3);
   localparam logic [WORD_W-1:0] RESET_D = seed_chain(RESET_C, 32'd4);

endpackage

### sv/xorshift128_random_source.sv
// Top level of the xorshift128 random source: front end, command queue and back end.
// Draw and range requests pass the command queue, execute and multiply registers and
// result queue, one per cycle while the result queue has room; a reseed holds the back end
// while its four chained 32x32 multiplies run one per cycle through a single multiplier.
// Reset (synchronous) empties both queues and loads the state of a reseed with zero;
// no clearing pass is needed, and requests are taken in the cycle after reset drops.
module xorshift128_random_source
   import xs128_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [1:0]               req_func,
   input  logic [WORD_W-1:0]        req_seed,
   input  logic signed [WORD_W-1:0] req_range_low,
   input  logic signed [WORD_W-1:0] req_range_high,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [WORD_W-1:0]        rsp_word,
   output logic signed [WORD_W-1:0] rsp_range_value,
   output logic                     rsp_range_error
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   xs128_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_seed       (req_seed),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_data),
      .cmd_pop        (cmd_pop)
   );

   xs128_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_data        (cmd_data),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .rsp_range_value (rsp_range_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule

### sv/xs128_front.sv
// Request front end: classifies each request and queues it for the back end.
module xs128_front
   import xs128_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [1:0]               req_func,
   input  logic [WORD_W-1:0]        req_seed,
   input  logic signed [WORD_W-1:0] req_range_low,
   input  logic signed [WORD_W-1:0] req_range_high,
   output logic                     cmd_valid,
   output cmd_type                  cmd_data,
   input  logic                     cmd_pop
);

   cmd_type              cmd_in;
   cmd_type              cmd_mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 push;

   // Equal and inverted bounds need no generator step, so they become fixed results.
   always_comb begin
      cmd_in.op   = OP_FIXED;
      cmd_in.seed = req_seed;
      cmd_in.low  = '0;
      cmd_in.diff = $unsigned(req_range_high) - $unsigned(req_range_low);
      cmd_in.err  = 1'b0;
      case (req_func)
         FUNC_SEED: begin
            cmd_in.op = OP_SEED;
         end
         FUNC_DRAW: begin
            cmd_in.op = OP_DRAW;
         end
         FUNC_RANGE: begin
            cmd_in.low = $unsigned(req_range_low);
            if (req_range_high < req_range_low) begin
               cmd_in.err = 1'b1;
            end else if (req_range_high != req_range_low) begin
               cmd_in.op = OP_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_full  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign push      = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = cmd_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? CMD_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? CMD_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = CMD_CNT_W'(count_ff + 1'b1);
      end else if (!push && cmd_pop) begin
         count_in = CMD_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### sv/xs128_back.sv
// Back end: generator state, reseed sequencer, range multiply pipeline and result queue.
module xs128_back
   import xs128_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd_data,
   output logic                     cmd_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [WORD_W-1:0]        rsp_word,
   output logic signed [WORD_W-1:0] rsp_range_value,
   output logic                     rsp_range_error
);

   logic [WORD_W-1:0]      state_a_ff, state_a_in;
   logic [WORD_W-1:0]      state_b_ff, state_b_in;
   logic [WORD_W-1:0]      state_c_ff, state_c_in;
   logic [WORD_W-1:0]      state_d_ff, state_d_in;
   logic                   seeding_ff, seeding_in;
   logic [SEED_STEP_W-1:0] seed_step_ff, seed_step_in;
   logic [WORD_W-1:0]      prod_ff, prod_in;
   logic [WORD_W-1:0]      seed_s;
   logic [WORD_W-1:0]      mix_src;
   logic [WORD_W-1:0]      shift_t;
   logic [WORD_W-1:0]      new_d;
   logic                   advance;

   logic                   m_valid_ff, m_valid_in;
   stage_type              m_ff, m_in;
   logic                   p_valid_ff;
   op_type                 p_op_ff;
   logic [WORD_W-1:0]      p_word_ff;
   logic [WORD_W-1:0]      p_low_ff;
   logic                   p_err_ff;
   logic [2*WORD_W-1:0]    p_prod_ff;
   logic [WORD_W:0]        low_sum;
   logic [WORD_W-1:0]      scaled;
   rsp_type                rsp_in;

   rsp_type                rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   q_wr_ptr_ff, q_wr_ptr_in;
   logic [RSP_PTR_W-1:0]   q_rd_ptr_ff, q_rd_ptr_in;
   logic [RSP_CNT_W-1:0]   q_count_ff, q_count_in;
   logic [RSP_CNT_W:0]     in_flight;
   logic                   credit_ok;
   logic                   q_pop;

   // Every request in the pipeline holds a slot in the result queue.
   assign in_flight = (RSP_CNT_W+1)'(q_count_ff) + (RSP_CNT_W+1)'(m_valid_ff)
                      + (RSP_CNT_W+1)'(p_valid_ff);
   assign credit_ok = (in_flight < (RSP_CNT_W+1)'(RSP_DEPTH));
   assign cmd_pop   = cmd_valid && !seeding_ff && credit_ok;
   assign advance   = cmd_pop && ((cmd_data.op == OP_DRAW) || (cmd_data.op == OP_RANGE));

   assign seed_s  = WORD_W'(prod_ff + WORD_W'(seed_step_ff) + 1'b1);
   assign mix_src = seeding_ff ? seed_s : cmd_data.seed;
   assign shift_t = state_a_ff ^ (state_a_ff << 11);
   assign new_d   = state_d_ff ^ (state_d_ff >> 19) ^ shift_t ^ (shift_t >> 8);

   always_comb begin
      state_a_in   = state_a_ff;
      state_b_in   = state_b_ff;
      state_c_in   = state_c_ff;
      state_d_in   = state_d_ff;
      prod_in      = seed_mix(mix_src);
      seeding_in   = seeding_ff;
      seed_step_in = '0;
      if (seeding_ff) begin
         // Each step finishes one state word and starts the multiply for the next.
         case (seed_step_ff)
            2'd0:    state_a_in = seed_s;
            2'd1:    state_b_in = seed_s;
            2'd2:    state_c_in = seed_s;
            default: state_d_in = seed_s;
         endcase
         seed_step_in = SEED_STEP_W'(seed_step_ff + 1'b1);
         seeding_in   = (seed_step_ff != SEED_LAST);
      end else if (advance) begin
         state_a_in = state_b_ff;
         state_b_in = state_c_ff;
         state_c_in = state_d_ff;
         state_d_in = new_d;
      end else if (cmd_pop && (cmd_data.op == OP_SEED)) begin
         seeding_in = 1'b1;
      end
   end

   always_comb begin
      m_valid_in = (cmd_pop && (cmd_data.op != OP_SEED))
                   || (seeding_ff && (seed_step_ff == SEED_LAST));
      m_in.op    = seeding_ff ? OP_SEED : cmd_data.op;
      m_in.word  = advance ? new_d : '0;
      m_in.low   = seeding_ff ? '0 : cmd_data.low;
      m_in.diff  = cmd_data.diff;
      m_in.err   = seeding_ff ? 1'b0 : cmd_data.err;
   end

   // floor(word * (diff + 1) / 2^32) is the high half of word * diff + word.
   always_comb begin
      low_sum = {1'b0, p_prod_ff[WORD_W-1:0]} + {1'b0, p_word_ff};
      scaled  = (p_op_ff == OP_RANGE)
                ? WORD_W'(p_prod_ff[2*WORD_W-1:WORD_W] + WORD_W'(low_sum[WORD_W]))
                : '0;
      rsp_in.word  = p_word_ff;
      rsp_in.value = WORD_W'(p_low_ff + scaled);
      rsp_in.err   = p_err_ff;
   end

   assign q_pop     = rsp_pop && !rsp_empty;
   assign rsp_empty = (q_count_ff == '0);

   always_comb begin
      q_wr_ptr_in = p_valid_ff ? RSP_PTR_W'(q_wr_ptr_ff + 1'b1) : q_wr_ptr_ff;
      q_rd_ptr_in = q_pop ? RSP_PTR_W'(q_rd_ptr_ff + 1'b1) : q_rd_ptr_ff;
      q_count_in  = q_count_ff;
      if (p_valid_ff && !q_pop) begin
         q_count_in = RSP_CNT_W'(q_count_ff + 1'b1);
      end else if (!p_valid_ff && q_pop) begin
         q_count_in = RSP_CNT_W'(q_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_a_ff   <= RESET_A;
         state_b_ff   <= RESET_B;
         state_c_ff   <= RESET_C;
         state_d_ff   <= RESET_D;
         seeding_ff   <= 1'b0;
         seed_step_ff <= '0;
         m_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         q_wr_ptr_ff  <= '0;
         q_rd_ptr_ff  <= '0;
         q_count_ff   <= '0;
      end else begin
         state_a_ff   <= state_a_in;
         state_b_ff   <= state_b_in;
         state_c_ff   <= state_c_in;
         state_d_ff   <= state_d_in;
         seeding_ff   <= seeding_in;
         seed_step_ff <= seed_step_in;
         m_valid_ff   <= m_valid_in;
         p_valid_ff   <= m_valid_ff;
         q_wr_ptr_ff  <= q_wr_ptr_in;
         q_rd_ptr_ff  <= q_rd_ptr_in;
         q_count_ff   <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      m_ff      <= m_in;
      p_op_ff   <= m_ff.op;
      p_word_ff <= m_ff.word;
      p_low_ff  <= m_ff.low;
      p_err_ff  <= m_ff.err;
      p_prod_ff <= m_ff.word * m_ff.diff;
      if (p_valid_ff) begin
         rsp_mem_ff[q_wr_ptr_ff] <= rsp_in;
      end
   end

   assign rsp_word        = rsp_mem_ff[q_rd_ptr_ff].word;
   assign rsp_range_value = $signed(rsp_mem_ff[q_rd_ptr_ff].value);
   assign rsp_range_error = rsp_mem_ff[q_rd_ptr_ff].err;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight <= (RSP_CNT_W+1)'(RSP_DEPTH))
      else $error("result queue overcommitted");

   a_no_issue_while_seeding: assert property (@(posedge clock) disable iff (reset)
      seeding_ff |-> !cmd_pop)
      else $error("request issued during reseed");

   a_seed_start: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && (cmd_data.op == OP_SEED)) |=> (seeding_ff && (seed_step_ff == '0)))
      else $error("reseed did not start");

   a_seed_finish: assert property (@(posedge clock) disable iff (reset)
      (seeding_ff && (seed_step_ff == SEED_LAST)) |=> (!seeding_ff && m_valid_ff))
      else $error("reseed did not finish with a result");
`endif

endmodule

### dv/xs128_checker.sv
// Checker for the xorshift128 random source: tracks the generator and checks every result.
module xs128_checker
   import xs128_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_full,
   input  logic [1:0]               req_func,
   input  logic [WORD_W-1:0]        req_seed,
   input  logic signed [WORD_W-1:0] req_range_low,
   input  logic signed [WORD_W-1:0] req_range_high,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  logic [WORD_W-1:0]        rsp_word,
   input  logic signed [WORD_W-1:0] rsp_range_value,
   input  logic                     rsp_range_error,
   output int                       errors,
   output int                       pending
);

   localparam logic [WORD_W-1:0] CHAIN_FACTOR = 32'd1812433253;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] value;
      logic              err;
   } draw_result_type;

   logic [WORD_W-1:0] gen_a, gen_b, gen_c, gen_d;
   draw_result_type   awaited_results[$];
   int                fail_count = 0;
   int                open_count = 0;

   assign errors  = fail_count;
   assign pending = open_count;

   function automatic logic [WORD_W-1:0] chain_next(input logic [WORD_W-1:0] s,
                                                    input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] folded;
      folded = s ^ (s >> 30);
      return folded * CHAIN_FACTOR + k;
   endfunction

   task automatic load_seed(input logic [WORD_W-1:0] s);
      gen_a = chain_next(s, 32'd1);
      gen_b = chain_next(gen_a, 32'd2);
      gen_c = chain_next(gen_b, 32'd3);
      gen_d = chain_next(gen_c, 32'd4);
   endtask

   task automatic step_generator(output logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] t;
      t     = gen_a ^ (gen_a << 11);
      gen_a = gen_b;
      gen_b = gen_c;
      gen_c = gen_d;
      gen_d = gen_d ^ (gen_d >> 19) ^ t ^ (t >> 8);
      w     = gen_d;
   endtask

   task automatic predict_draw(input logic [1:0] func,
                               input logic [WORD_W-1:0] seed,
                               input logic signed [WORD_W-1:0] lo,
                               input logic signed [WORD_W-1:0] hi,
                               output draw_result_type r);
      logic [63:0]       span;
      logic [63:0]       prod;
      logic [WORD_W-1:0] w;
      r.word  = '0;
      r.value = '0;
      r.err   = 1'b0;
      case (func)
         FUNC_SEED: load_seed(seed);
         FUNC_DRAW: begin
            step_generator(w);
            r.word = w;
         end
         FUNC_RANGE: begin
            if (hi < lo) begin
               r.value = lo;
               r.err   = 1'b1;
            end else if (hi == lo) begin
               r.value = lo;
            end else begin
               // The span reaches 2^32 for the full signed range, so it needs 33 bits.
               span = 64'(longint'(hi) - longint'(lo)) + 64'd1;
               step_generator(w);
               prod    = {32'd0, w} * span;
               r.word  = w;
               r.value = lo + prod[63:32];
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      draw_result_type oldest;
      draw_result_type fresh;
      if (reset) begin
         load_seed('0);
         awaited_results.delete();
         open_count = 0;
      end else begin
         // Results are checked before the request of the same edge is added.
         if (rsp_pop && !rsp_empty) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               $error("result with no request waiting: word %h value %h error %b",
                      rsp_word, rsp_range_value, rsp_range_error);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_word !== oldest.word) begin
                  fail_count++;
                  $error("word mismatch: expected %h, actual %h", oldest.word, rsp_word);
               end
               if (rsp_range_value !== oldest.value) begin
                  fail_count++;
                  $error("range_value mismatch: expected %h, actual %h",
                         oldest.value, rsp_range_value);
               end
               if (rsp_range_error !== oldest.err) begin
                  fail_count++;
                  $error("range_error mismatch: expected %b, actual %b",
                         oldest.err, rsp_range_error);
               end
            end
         end
         if (req_push && !req_full) begin
            predict_draw(req_func, req_seed, req_range_low, req_range_high, fresh);
            awaited_results.push_back(fresh);
         end
         open_count = awaited_results.size();
      end
   end

endmodule

### dv/tb_xorshift128_random_source.sv
// Testbench top for the xorshift128 random source: clock, reset, request stimulus and verdict.
module tb_xorshift128_random_source;
   import xs128_pkg::*;

   localparam logic [1:0]               FUNC_SPARE  = 2'd3;
   localparam logic signed [WORD_W-1:0] RANGE_MIN   = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] RANGE_MAX   = 32'sh7FFF_FFFF;
   localparam int                       PHASE_ITEMS = 460;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_push       = 1'b0;
   logic                     req_full;
   logic [1:0]               req_func       = FUNC_DRAW;
   logic [WORD_W-1:0]        req_seed       = '0;
   logic signed [WORD_W-1:0] req_range_low  = '0;
   logic signed [WORD_W-1:0] req_range_high = '0;
   logic                     rsp_empty;
   logic                     rsp_pop        = 1'b0;
   logic [WORD_W-1:0]        rsp_word;
   logic signed [WORD_W-1:0] rsp_range_value;
   logic                     rsp_range_error;

   int send_idle = 36;
   int recv_idle = 59;
   int errors;
   int pending;

   initial begin
      forever #1 clock = ~clock;
   end

   xorshift128_random_source u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_seed        (req_seed),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .rsp_range_value (rsp_range_value),
      .rsp_range_error (rsp_range_error)
   );

   xs128_checker u_rsp_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_seed        (req_seed),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_word        (rsp_word),
      .rsp_range_value (rsp_range_value),
      .rsp_range_error (rsp_range_error),
      .errors          (errors),
      .pending         (pending)
   );

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle);
   end

   // Holds the request on the ports until the block takes it.
   task automatic send_request(input logic [1:0] f, input logic [WORD_W-1:0] s,
                               input logic signed [WORD_W-1:0] lo,
                               input logic signed [WORD_W-1:0] hi);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_func       <= f;
      req_seed       <= s;
      req_range_low  <= lo;
      req_range_high <= hi;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_random();
      logic [1:0]               f;
      logic [WORD_W-1:0]        s;
      logic signed [WORD_W-1:0] lo;
      logic signed [WORD_W-1:0] hi;
      int                       pick;
      pick = $urandom_range(99);
      if (pick < 12)      f = FUNC_SEED;
      else if (pick < 50) f = FUNC_DRAW;
      else if (pick < 92) f = FUNC_RANGE;
      else                f = FUNC_SPARE;
      s  = $urandom;
      lo = $urandom;
      hi = $urandom;
      case ($urandom_range(9))
         0, 1, 2, 3: ;
         4, 5: hi = lo + $urandom_range(255);
         6: hi = lo;
         7: begin
            lo = RANGE_MIN;
            hi = RANGE_MAX;
         end
         8: begin
            lo = RANGE_MIN + $urandom_range(15);
            hi = RANGE_MAX - $urandom_range(15);
         end
         default: hi = lo - $urandom_range(255, 1);
      endcase
      if ($urandom_range(15) == 0) s = $urandom_range(1) ? '1 : '0;
      send_request(f, s, lo, hi);
   endtask

   // The sender stays quiet until every outstanding request has been answered.
   task automatic drain_results();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Draws straight from the reset state, then bound extremes and reseeds.
      send_request(FUNC_DRAW, '0, 0, 0);
      send_request(FUNC_DRAW, '1, -1, -1);
      send_request(FUNC_RANGE, '0, RANGE_MIN, RANGE_MAX);
      send_request(FUNC_RANGE, '0, 0, 1);
      send_request(FUNC_RANGE, '1, -1, 0);
      send_request(FUNC_RANGE, '0, RANGE_MIN, RANGE_MIN);
      send_request(FUNC_RANGE, '0, RANGE_MAX, RANGE_MAX);
      send_request(FUNC_RANGE, '0, RANGE_MAX, RANGE_MIN);
      send_request(FUNC_RANGE, '0, 1, 0);
      send_request(FUNC_RANGE, '0, RANGE_MAX - 1, RANGE_MAX);
      send_request(FUNC_RANGE, '0, RANGE_MIN, RANGE_MIN + 1);
      send_request(FUNC_SPARE, '1, -1, -1);
      send_request(FUNC_SEED, '0, 0, 0);
      send_request(FUNC_DRAW, '0, 0, 0);
      send_request(FUNC_SEED, '1, -1, -1);
      send_request(FUNC_DRAW, '0, 0, 0);
      send_request(FUNC_RANGE, '0, 10, 20);
      send_request(FUNC_SEED, 32'h8000_0000, RANGE_MIN, RANGE_MAX);
      send_request(FUNC_RANGE, '0, -100, 100);
      send_request(FUNC_SPARE, '0, 0, 0);
      send_request(FUNC_DRAW, '0, 0, 0);
      send_request(FUNC_SEED, 32'h1234_5678, 0, 0);
      send_request(FUNC_RANGE, '0, RANGE_MIN, RANGE_MAX);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 36;
               recv_idle = 59;
            end
            1: begin
               send_idle = 59;
               recv_idle = 36;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         repeat (PHASE_ITEMS) send_random();
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
sv/xs128_pkg.sv
sv/xs128_front.sv
sv/xs128_back.sv
sv/xorshift128_random_source.sv
dv/xs128_checker.sv
dv/tb_xorshift128_random_source.sv
